[src/etl_pkg.sv]
// ----------------------------------------------------------------------------
// etl_pkg
// Shared types and constants for the tour length unit.
// ----------------------------------------------------------------------------
package etl_pkg;

    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int LEG_W   = 17;
    localparam int TOTAL_W = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_VISIT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_PREV,
        S_RD_CUR,
        S_DIFF,
        S_MUL,
        S_SQ_GO,
        S_ROOT,
        S_ACC,
        S_DONE
    } t_state;

endpackage

[src/etl_ram.sv]
// ----------------------------------------------------------------------------
// etl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module etl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/etl_sqrt.sv]
// ----------------------------------------------------------------------------
// etl_sqrt
// Iterative floored integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module etl_sqrt #(
    parameter int ROOT_W = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2*ROOT_W-2:0]   i_radicand,
    output logic                  o_done,
    output logic [ROOT_W-1:0]     o_root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int TRY_W = ROOT_W + 4;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rad,  n_rad;
    logic [REM_W-1:0]  r_rem,  n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [TRY_W-1:0]  w_rem_sh;
    logic [TRY_W-1:0]  w_trial;

    always_comb begin
        w_rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
        w_trial  = TRY_W'({r_root, 2'b01});
        n_rad    = r_rad;
        n_rem    = r_rem;
        n_root   = r_root;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_start) begin
            n_rad  = RAD_W'(i_radicand);
            n_rem  = '0;
            n_root = '0;
            n_cnt  = CNT_W'(ROOT_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad = r_rad << 2;
            if (w_rem_sh >= w_trial) begin
                n_rem  = REM_W'(w_rem_sh - w_trial);
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = REM_W'(w_rem_sh);
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[src/euclidean_tour_length.sv]
// ----------------------------------------------------------------------------
// euclidean_tour_length
// Route length accumulator over a table of Q10.6 city coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on the i_ ports with i_start high; it transfers on the edge
//   where o_busy is low. A write (op = write) stores one city's coordinates in
//   that same cycle and gives no result. A visit gives one result, shown for
//   exactly one cycle with o_done high.
//   An invalid index or the first city of a route gives its result in the
//   cycle after the transfer. A leg between two cities reads both entries
//   from the table RAM, squares, and runs the square root unit one root bit
//   per cycle. Either way, the next item transfers only after the result
//   has been shown. The user must ensure the city count register is written
//   via i_cfg_we / i_cfg_wdata only while idle; the block does not enforce it.
//   Reset clears the count, the running total and the route state; table
//   contents are undefined until written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module euclidean_tour_length #(
    parameter int MAX_CITIES = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_op,
    input  logic [etl_pkg::INDEX_W-1:0]   i_city_index,
    input  logic [COORD_BITS-1:0]         i_x_coord,
    input  logic [COORD_BITS-1:0]         i_y_coord,
    input  logic                          i_route_start,
    output logic                          o_done,
    output logic [etl_pkg::LEG_W-1:0]     o_leg_length,
    output logic [etl_pkg::TOTAL_W-1:0]   o_total_length,
    output logic                          o_index_error,
    input  logic                          i_cfg_we,
    input  logic [etl_pkg::COUNT_W-1:0]   i_cfg_wdata
);

    import etl_pkg::*;

    localparam int ADDR_W = $clog2(MAX_CITIES);
    localparam int DATA_W = 2 * COORD_BITS;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int RAD_W  = 2 * COORD_BITS + 1;
    localparam int ROOT_W = COORD_BITS + 1;

    t_state                r_state, n_state;
    logic [COUNT_W-1:0]    r_count;
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic                  r_have_prev, n_have_prev;
    logic [INDEX_W-1:0]    r_prev_city, n_prev_city;

    logic [INDEX_W-1:0]    r_idx, n_idx;
    logic [COORD_BITS-1:0] r_px, n_px, r_py, n_py;
    logic [COORD_BITS-1:0] r_dx, n_dx, r_dy, n_dy;
    logic [SQ_W-1:0]       r_sqx, r_sqy;
    logic [LEG_W-1:0]      r_leg, n_leg;
    logic                  r_err, n_err;

    logic                  w_accept;
    logic                  w_in_table;
    logic                  w_valid_visit;
    logic                  w_ram_we;
    logic [ADDR_W-1:0]     w_raddr;
    logic [DATA_W-1:0]     w_rdata;
    logic [COORD_BITS-1:0] w_cx, w_cy;
    logic [RAD_W-1:0]      w_radicand;
    logic [ROOT_W-1:0]     w_root;
    logic [TOTAL_W:0]      w_sum;
    logic                  w_sq_start;
    logic                  w_sq_done;

    assign w_accept      = i_start && !o_busy;
    assign w_in_table    = 32'(i_city_index) < MAX_CITIES;
    assign w_valid_visit = w_in_table && ({1'b0, i_city_index} < r_count);
    assign w_ram_we      = w_accept && (i_op == OP_WRITE) && w_in_table;
    assign w_raddr       = (r_state == S_RD_PREV) ? ADDR_W'(r_prev_city) : ADDR_W'(r_idx);
    assign w_cx          = w_rdata[DATA_W-1 -: COORD_BITS];
    assign w_cy          = w_rdata[COORD_BITS-1:0];
    assign w_radicand    = RAD_W'(r_sqx) + RAD_W'(r_sqy);
    assign w_sum         = {1'b0, r_total} + (TOTAL_W+1)'(w_root);

    etl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_CITIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (ADDR_W'(i_city_index)),
        .i_wdata ({i_x_coord, i_y_coord}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    etl_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (w_radicand),
        .o_done     (w_sq_done),
        .o_root     (w_root)
    );

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_have_prev = r_have_prev;
        n_prev_city = r_prev_city;
        n_idx       = r_idx;
        n_px        = r_px;
        n_py        = r_py;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_leg       = r_leg;
        n_err       = r_err;
        w_sq_start  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_op == OP_VISIT)) begin
                    if (i_route_start) begin
                        n_total     = '0;
                        n_have_prev = 1'b0;
                    end
                    n_leg = '0;
                    if (!w_valid_visit) begin
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else if (i_route_start || !r_have_prev) begin
                        n_err       = 1'b0;
                        n_prev_city = i_city_index;
                        n_have_prev = 1'b1;
                        n_state     = S_DONE;
                    end else begin
                        n_err   = 1'b0;
                        n_idx   = i_city_index;
                        n_state = S_RD_PREV;
                    end
                end
            end
            S_RD_PREV: n_state = S_RD_CUR;
            S_RD_CUR: begin
                n_px    = w_cx;
                n_py    = w_cy;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_dx    = (w_cx >= r_px) ? (w_cx - r_px) : (r_px - w_cx);
                n_dy    = (w_cy >= r_py) ? (w_cy - r_py) : (r_py - w_cy);
                n_state = S_MUL;
            end
            S_MUL: n_state = S_SQ_GO;
            S_SQ_GO: begin
                w_sq_start = 1'b1;
                n_state    = S_ROOT;
            end
            S_ROOT: begin
                if (w_sq_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_total     = w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];
                n_leg       = LEG_W'(w_root);
                n_prev_city = r_idx;
                n_have_prev = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_have_prev <= 1'b0;
            r_prev_city <= '0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_have_prev <= n_have_prev;
            r_prev_city <= n_prev_city;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_px  <= n_px;
        r_py  <= n_py;
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_sqx <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_sqy <= SQ_W'(r_dy) * SQ_W'(r_dy);
        r_leg <= n_leg;
        r_err <= n_err;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = (r_state == S_DONE);
    assign o_leg_length   = r_leg;
    assign o_total_length = r_total;
    assign o_index_error  = r_err;

    a_sqrt_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> (r_state == S_ROOT))
        else $error("square root finished outside the root wait state");

    a_error_zero_leg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_index_error) |-> (o_leg_length == '0))
        else $error("invalid visit reported a nonzero leg");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_WRITE)) |=> !o_done)
        else $error("write transfer produced a result");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |=> (r_total >= $past(r_total)))
        else $error("running total decreased on a leg");

    a_leg_needs_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_leg_length != '0)) |-> r_have_prev)
        else $error("leg reported without a previous city");

endmodule
